[sv/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and codes for the DLE/STX/ETX byte-stuffing deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned HdrCntW  = 3;
  localparam int unsigned HeaderLen = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutDataW = 64;

  localparam logic [ByteW-1:0] EscapeReset = 8'd16;
  localparam logic [ByteW-1:0] StartReset  = 8'd2;
  localparam logic [ByteW-1:0] EndReset    = 8'd3;

  // parser phase codes
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_HUNT_ESC   = 3'd0;
  localparam logic [PhaseW-1:0] PH_HUNT_START = 3'd1;
  localparam logic [PhaseW-1:0] PH_BODY       = 3'd2;
  localparam logic [PhaseW-1:0] PH_BODY_ESC   = 3'd3;
  localparam logic [PhaseW-1:0] PH_DROP       = 3'd4;

  // header byte positions
  localparam logic [HdrCntW-1:0] HDR_KIND   = 3'd0;
  localparam logic [HdrCntW-1:0] HDR_FORMAT = 3'd5;
  localparam logic [HdrCntW-1:0] HDR_FULL   = 3'd6;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_DONE    = 2'd1,
    EV_ERROR   = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_BAD_PAIR  = 3'd2,
    ERR_SHORT     = 3'd3,
    ERR_END       = 3'd4
  } error_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ESCAPE = 2'd0,
    CFG_START  = 2'd1,
    CFG_END    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
  } cfg_t;

  typedef struct packed {
    event_e           event_res;
    logic [ByteW-1:0] frame_kind;
    logic [KeyW-1:0]  key_ident;
    logic [ByteW-1:0] payload_format;
    logic [ByteW-1:0] payload_value;
    error_e           error_code;
  } result_t;

endpackage

`default_nettype wire

[sv/dfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dfr_cfg_regs
// Escape, start and end code registers behind a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dfr_pkg::ByteW-1:0]   cfg_data_i,
  output      dfr_pkg::cfg_t               cfg_o
);
  import dfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ESCAPE: cfg_d.escape_code = cfg_data_i;
        CFG_START:  cfg_d.start_code  = cfg_data_i;
        CFG_END:    cfg_d.end_code    = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_code <= EscapeReset;
      cfg_q.start_code  <= StartReset;
      cfg_q.end_code    <= EndReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/dfr_parser.sv]
// ----------------------------------------------------------------------------
// dfr_parser
// Per-byte frame state machine: start hunt, de-stuffing, header capture and
// result generation for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  input  wire logic [dfr_pkg::ByteW-1:0] byte_value_i,
  input  wire logic                      end_of_buffer_i,
  input       dfr_pkg::cfg_t             cfg_i,
  output      logic                      res_valid_o,
  output      dfr_pkg::result_t          res_o
);
  import dfr_pkg::*;

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [ByteW-1:0]   kind_q, kind_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [ByteW-1:0]   fmt_q, fmt_d;

  logic   is_esc, is_start, is_end, last, hdr_full;
  logic   body_take;
  logic   emit_err, emit_payload, emit_done;
  error_e err;

  assign is_esc   = (byte_value_i == cfg_i.escape_code);
  assign is_start = (byte_value_i == cfg_i.start_code);
  assign is_end   = (byte_value_i == cfg_i.end_code);
  assign last     = end_of_buffer_i;
  assign hdr_full = (hdr_cnt_q == HDR_FULL);

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    kind_d       = kind_q;
    key_d        = key_q;
    fmt_d        = fmt_q;
    body_take    = 1'b0;
    emit_err     = 1'b0;
    emit_payload = 1'b0;
    emit_done    = 1'b0;
    err          = ERR_NONE;

    unique case (phase_q)
      PH_HUNT_START: begin
        if (!is_start) begin
          emit_err = 1'b1;
          err      = ERR_BAD_START;
        end else begin
          hdr_cnt_d = '0;
          kind_d    = '0;
          key_d     = '0;
          fmt_d     = '0;
          if (last) begin
            emit_err = 1'b1;
            err      = ERR_END;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (is_esc) begin
          if (last) begin
            emit_err = 1'b1;
            err      = ERR_END;
          end else begin
            phase_d = PH_BODY_ESC;
          end
        end else begin
          body_take = 1'b1;
        end
      end
      PH_BODY_ESC: begin
        priority if (is_end) begin
          phase_d = PH_HUNT_ESC;
          if (!hdr_full) begin
            emit_err = 1'b1;
            err      = ERR_SHORT;
          end else begin
            emit_done = 1'b1;
          end
        end else if (is_esc) begin
          phase_d   = PH_BODY;
          body_take = 1'b1;
        end else begin
          emit_err = 1'b1;
          err      = ERR_BAD_PAIR;
        end
      end
      PH_DROP: begin
        if (last) begin
          phase_d = PH_HUNT_ESC;
        end
      end
      default: begin
        if (last) begin
          emit_err = 1'b1;
          err      = ERR_END;
        end else if (!is_esc) begin
          emit_err = 1'b1;
          err      = ERR_BAD_START;
        end else begin
          phase_d = PH_HUNT_START;
        end
      end
    endcase

    // one de-stuffed body byte
    if (body_take) begin
      if (last) begin
        emit_err = 1'b1;
        err      = ERR_END;
      end else if (!hdr_full) begin
        priority if (hdr_cnt_q == HDR_KIND) begin
          kind_d = byte_value_i;
        end else if (hdr_cnt_q == HDR_FORMAT) begin
          fmt_d = byte_value_i;
        end else begin
          key_d = {key_q[KeyW-ByteW-1:0], byte_value_i};
        end
        hdr_cnt_d = hdr_cnt_q + 1'b1;
      end else begin
        emit_payload = 1'b1;
      end
    end

    if (emit_err) begin
      phase_d = (last || err == ERR_SHORT) ? PH_HUNT_ESC : PH_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT_ESC;
      hdr_cnt_q <= '0;
      kind_q    <= '0;
      key_q     <= '0;
      fmt_q     <= '0;
    end else if (item_valid_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      kind_q    <= kind_d;
      key_q     <= key_d;
      fmt_q     <= fmt_d;
    end
  end

  always_comb begin
    res_valid_o          = item_valid_i && (emit_err || emit_payload || emit_done);
    res_o.event_res      = emit_err ? EV_ERROR : (emit_done ? EV_DONE : EV_PAYLOAD);
    res_o.frame_kind     = emit_err ? '0 : kind_q;
    res_o.key_ident      = emit_err ? '0 : key_q;
    res_o.payload_format = emit_err ? '0 : fmt_q;
    res_o.payload_value  = emit_payload ? byte_value_i : '0;
    res_o.error_code     = err;
  end

endmodule

`default_nettype wire

[sv/dfr_out_reg.sv]
// ----------------------------------------------------------------------------
// dfr_out_reg
// Result register on the master stream side with tdata/tuser packing.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_out_reg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         res_valid_i,
  input       dfr_pkg::result_t             res_i,
  output      logic                         ready_o,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [dfr_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic [1:0]                   m_axis_tuser
);
  import dfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;
  assign valid_d = ready_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tdata  = {5'b0, res_q.error_code, res_q.payload_value,
                          res_q.payload_format, res_q.key_ident, res_q.frame_kind};

endmodule

`default_nettype wire

[sv/dle_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// dle_frame_deframer_unit
// DLE/STX/ETX byte-stuffing deframer: one raw byte per item in, payload bytes
// with their frame header, frame-done and error items out.
//
//  port group   dir  contents
//  s_axis_*     in   tdata[7:0] byte_value, tlast end_of_buffer
//  m_axis_*     out  tuser[1:0] event_res, tdata frame/header/payload/error
//  cfg_*        in   write of escape (0), start (1), end (2) codes
//
// one item per cycle sustained while the master side accepts; an item waits
// in the input register and its result, if any, in the result register
// reset returns the parser to start hunt and the codes to 16, 2, 3
// a stall on the master side holds the result and backs up through the
// input register to s_axis_tready
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_deframer_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // byte_value
  input  wire logic                         s_axis_tlast,  // end_of_buffer
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // frame_kind[7:0], key_ident[39:8], payload_format[47:40],
  // payload_value[55:48], error_code[58:56], zero fill
  output      logic [dfr_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic [1:0]                   m_axis_tuser,  // event_res
  input  wire logic                         cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dfr_pkg::ByteW-1:0]    cfg_data_i
);
  import dfr_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_ready;
  logic             consume;
  logic             res_valid;
  result_t          res;

  dfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign consume       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  dfr_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (consume),
    .byte_value_i    (in_byte_q),
    .end_of_buffer_i (in_last_q),
    .cfg_i           (cfg),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  dfr_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[bench/dle_frame_deframer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_frame_deframer_unit_test
// Self-checking bench for the byte-stuffing deframer. Raw link bytes go in on
// the s_axis side; a local model of the parser predicts each payload, frame
// done and error item, and every m_axis item is compared field by field with
// the oldest prediction. Directed frames and framing errors come first, then
// mostly well-formed random buffers mixed with noise, truncated and corrupted
// frames, under several code settings and backpressure patterns.
// ----------------------------------------------------------------------------

module dle_frame_deframer_unit_test;
  import dfr_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 4;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [ByteW-1:0]    cfg_data_i    = '0;

  dle_frame_deframer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // parser model state
  logic [PhaseW-1:0]  rx_phase   = PH_HUNT_ESC;
  logic [HdrCntW-1:0] hdr_count  = '0;
  logic [7:0]         hdr_kind   = '0;
  logic [31:0]        hdr_key    = '0;
  logic [7:0]         hdr_format = '0;
  logic [7:0]         esc_code   = EscapeReset;
  logic [7:0]         stx_code   = StartReset;
  logic [7:0]         etx_code   = EndReset;

  result_t     expected_results[$];
  logic [7:0]  link_buf[$];
  int          fail_count    = 0;
  int          idle_cycles   = 0;
  int          items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic append_byte(logic [7:0] b);
    link_buf = {link_buf, b};
  endtask

  task automatic queue_result(event_e ev, bit with_hdr, logic [7:0] value, error_e err);
    result_t r;
    r.event_res      = ev;
    r.frame_kind     = with_hdr ? hdr_kind : '0;
    r.key_ident      = with_hdr ? hdr_key : '0;
    r.payload_format = with_hdr ? hdr_format : '0;
    r.payload_value  = value;
    r.error_code     = err;
    expected_results = {expected_results, r};
  endtask

  task automatic report_fault(error_e err, logic last);
    rx_phase = last ? PH_HUNT_ESC : PH_DROP;
    queue_result(EV_ERROR, 1'b0, 8'h00, err);
  endtask

  task automatic take_body_byte(logic [7:0] b, logic last);
    if (last) begin
      report_fault(ERR_END, 1'b1);
    end else if (hdr_count < HeaderLen) begin
      if (hdr_count == HDR_KIND) hdr_kind = b;
      else if (hdr_count == HDR_FORMAT) hdr_format = b;
      else hdr_key = {hdr_key[23:0], b};
      hdr_count = hdr_count + 1'b1;
    end else begin
      queue_result(EV_PAYLOAD, 1'b1, b, ERR_NONE);
    end
  endtask

  task automatic deframe_byte(logic [7:0] b, logic last);
    case (rx_phase)
      PH_HUNT_START: begin
        if (b != stx_code) begin
          report_fault(ERR_BAD_START, last);
        end else begin
          hdr_count  = '0;
          hdr_kind   = '0;
          hdr_key    = '0;
          hdr_format = '0;
          if (last) report_fault(ERR_END, 1'b1);
          else rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (b == esc_code) begin
          if (last) report_fault(ERR_END, 1'b1);
          else rx_phase = PH_BODY_ESC;
        end else begin
          take_body_byte(b, last);
        end
      end
      PH_BODY_ESC: begin
        // end code wins when it equals the escape code
        if (b == etx_code) begin
          rx_phase = PH_HUNT_ESC;
          if (hdr_count < HeaderLen) report_fault(ERR_SHORT, 1'b1);
          else queue_result(EV_DONE, 1'b1, 8'h00, ERR_NONE);
        end else if (b == esc_code) begin
          rx_phase = PH_BODY;
          take_body_byte(b, last);
        end else begin
          report_fault(ERR_BAD_PAIR, last);
        end
      end
      PH_DROP: begin
        if (last) rx_phase = PH_HUNT_ESC;
      end
      default: begin
        if (last) report_fault(ERR_END, 1'b1);
        else if (b != esc_code) report_fault(ERR_BAD_START, 1'b0);
        else rx_phase = PH_HUNT_START;
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected item, expected none actual tuser %h tdata %h",
               $time, m_axis_tuser, m_axis_tdata);
    end else begin
      want = expected_results.pop_front();
      compare_field("event_res", 32'(want.event_res), 32'(m_axis_tuser));
      compare_field("frame_kind", 32'(want.frame_kind), 32'(m_axis_tdata[7:0]));
      compare_field("key_ident", want.key_ident, m_axis_tdata[39:8]);
      compare_field("payload_format", 32'(want.payload_format),
                    32'(m_axis_tdata[47:40]));
      compare_field("payload_value", 32'(want.payload_value), 32'(m_axis_tdata[55:48]));
      compare_field("error_code", 32'(want.error_code), 32'(m_axis_tdata[58:56]));
      compare_field("zero fill", '0, 32'(m_axis_tdata[63:59]));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata, s_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("dle_frame_deframer_unit test failed");
    $finish;
  end

  task automatic send_link_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_buffer();
    foreach (link_buf[i]) send_link_byte(link_buf[i], i == link_buf.size() - 1);
    items_sent += link_buf.size();
  endtask

  // hold the sender until every predicted item has come out
  task automatic wait_results(int unsigned extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_codes(logic [7:0] esc, logic [7:0] stx, logic [7:0] etx);
    wait_results(SettleCycles);
    write_reg(CFG_ESCAPE, esc);
    write_reg(CFG_START, stx);
    write_reg(CFG_END, etx);
    cfg_we_i <= 1'b0;
    esc_code = esc;
    stx_code = stx;
    etx_code = etx;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return esc_code;
      1: return stx_code;
      2: return etx_code;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic append_frame();
    int unsigned body_len;
    logic [7:0]  b;
    body_len = ($urandom_range(7) == 0) ? $urandom_range(5) : 6 + $urandom_range(8);
    append_byte(esc_code);
    append_byte(stx_code);
    repeat (body_len) begin
      b = pick_byte();
      append_byte(b);
      if (b == esc_code) append_byte(b);
    end
    append_byte(esc_code);
    append_byte(etx_code);
  endtask

  task automatic test_stuffed_frame();
    // header 00 / 10ff0080 / ff with a stuffed escape, payload 10 and 00
    link_buf = '{8'h10, 8'h02, 8'h00, 8'h10, 8'h10, 8'hFF, 8'h00, 8'h80, 8'hFF,
                 8'h10, 8'h10, 8'h00, 8'h10, 8'h03};
    send_buffer();
  endtask

  task automatic test_framing_errors();
    link_buf = '{8'h10};                             // end where a frame starts
    send_buffer();
    link_buf = '{8'h42};                             // end wins over bad first byte
    send_buffer();
    link_buf = '{8'h10, 8'h05, 8'h10};               // bad second byte, drop
    send_buffer();
    link_buf = '{8'h10, 8'h02, 8'h33, 8'h10, 8'h03}; // body too short
    send_buffer();
    link_buf = '{8'h10, 8'h02, 8'h10, 8'h44};        // unknown pair on last
    send_buffer();
    link_buf = '{8'h10, 8'h02, 8'h77};               // end inside a frame
    send_buffer();
  endtask

  task automatic test_escape_ambiguity();
    // escape equals end code, so a doubled escape closes the frame
    set_codes(8'h00, 8'hFF, 8'h00);
    link_buf = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                 8'h00, 8'h00};
    send_buffer();
  endtask

  task automatic test_random_traffic(logic [7:0] esc, logic [7:0] stx, logic [7:0] etx,
                                     int unsigned num_items);
    int unsigned stop_at;
    int unsigned cut;
    set_codes(esc, stx, etx);
    stop_at = items_sent + num_items;
    while (items_sent < stop_at) begin
      link_buf.delete();
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 6)) append_byte(pick_byte());
        end
        1: begin
          append_frame();
          cut = $urandom_range(1, link_buf.size());
          while (link_buf.size() > cut) void'(link_buf.pop_back());
        end
        2: begin
          append_frame();
          link_buf[$urandom_range(link_buf.size() - 1)] = 8'($urandom_range(255));
        end
        default: begin
          repeat ($urandom_range(1, 3)) append_frame();
        end
      endcase
      send_buffer();
      if ($urandom_range(39) == 0) wait_results(0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 47;
    test_stuffed_frame();
    test_framing_errors();
    test_escape_ambiguity();
    test_random_traffic(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 150);

    send_idle_pct = 47;
    recv_idle_pct = 21;
    test_random_traffic(8'hFF, 8'h00, 8'hFF, 150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(EscapeReset, StartReset, EndReset, 150);
    test_random_traffic(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 150);

    wait_results(8);
    if (fail_count == 0) begin
      $display("dle_frame_deframer_unit test passed");
    end else begin
      $display("dle_frame_deframer_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/dfr_pkg.sv
sv/dfr_cfg_regs.sv
sv/dfr_parser.sv
sv/dfr_out_reg.sv
sv/dle_frame_deframer_unit.sv
bench/dle_frame_deframer_unit_test.sv
